>>> hdl/backemf_angle_speed_estimator_defines.svh
// Assertion macros for the back-EMF angle and speed estimator
`ifndef BACKEMF_ANGLE_SPEED_ESTIMATOR_DEFINES_SVH
`define BACKEMF_ANGLE_SPEED_ESTIMATOR_DEFINES_SVH

// same-cycle implication, checked on clock, off during reset
`define BEMF_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bemf assertion failed");

// next-cycle implication
`define BEMF_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bemf assertion failed");

`endif

>>> hdl/bemf_pkg.sv
// Shared types, constants and tables of the back-EMF estimator
`timescale 1ns / 1ps
`default_nettype none
package bemf_pkg;

   localparam int PolePairsDefault     = 4;
   localparam int WindowSamplesDefault = 20;
   localparam int CordicStagesDefault  = 16;

   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   localparam logic [CsrIdxWidth-1:0] CSR_ROTATION_CW = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DELTA_GAIN  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MIN_FLOOR   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KAFC_SCALE  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_RPM_SHIFT   = 3'd4;

   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [15:0] Q15_ONE_M1   = 16'd32768;
   localparam logic [16:0] ERPM_FACTOR  = 17'd60000;
   localparam logic [23:0] SIXTY_NUM    = 24'd10000000;

   typedef struct packed {
      logic signed [15:0] emf_alpha;
      logic signed [15:0] emf_beta;
   } req_type;

   typedef struct packed {
      logic [15:0] comp_angle;
      logic [15:0] raw_angle;
      logic [15:0] mech_rpm;
      logic [20:0] sixty_deg_time;
      logic [14:0] observer_coeff;
   } rsp_type;

   typedef struct packed {
      logic        rotation_cw;
      logic [15:0] delta_filter_gain;
      logic [14:0] min_delta_floor;
      logic [15:0] kafc_scale;
      logic [3:0]  rpm_filter_shift;
   } cfg_type;

   // atan(2^-i) in units of 2^-24 turn
   function automatic logic [21:0] atan_lut(input logic [4:0] idx);
      logic [21:0] v;
      unique case (idx)
         5'd0:  v = 22'd2097152;
         5'd1:  v = 22'd1238021;
         5'd2:  v = 22'd654136;
         5'd3:  v = 22'd332050;
         5'd4:  v = 22'd166669;
         5'd5:  v = 22'd83416;
         5'd6:  v = 22'd41718;
         5'd7:  v = 22'd20860;
         5'd8:  v = 22'd10430;
         5'd9:  v = 22'd5215;
         5'd10: v = 22'd2608;
         5'd11: v = 22'd1304;
         5'd12: v = 22'd652;
         5'd13: v = 22'd326;
         5'd14: v = 22'd163;
         5'd15: v = 22'd81;
         5'd16: v = 22'd41;
         5'd17: v = 22'd20;
         5'd18: v = 22'd10;
         5'd19: v = 22'd5;
         5'd20: v = 22'd3;
         5'd21: v = 22'd1;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> hdl/backemf_angle_speed_estimator.sv
// A sample passes the iterative CORDIC, the angle and window update, the delta filter,
// the eRPM scaling, the smoothing filters, the RPM scaling and, when the speed is
// nonzero, the 24-step restoring 60-degree divider, then the coefficient step.
// No new sample is taken until the result of the last one has been handed off.
// A two-beat input queue and a one-beat result register decouple both sides.
// Reset (synchronous, active high) clears filters, window and CSRs to defaults.
`timescale 1ns / 1ps
`default_nettype none
module backemf_angle_speed_estimator #(
   parameter int POLE_PAIRS     = bemf_pkg::PolePairsDefault,
   parameter int WINDOW_SAMPLES = bemf_pkg::WindowSamplesDefault,
   parameter int CORDIC_STAGES  = bemf_pkg::CordicStagesDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire bemf_pkg::req_type                     req_data,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output bemf_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [bemf_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [bemf_pkg::CsrDataWidth-1:0]     csr_data
);
   import bemf_pkg::*;
   `include "backemf_angle_speed_estimator_defines.svh"

   cfg_type cfg_ff, cfg_in;
   req_type q_data;
   rsp_type res_data, out_ff;
   logic    q_valid, q_pop, res_valid, res_ready;
   logic    out_vld_ff, out_vld_in;

   // CSR writes are always accepted and registered in the configuration register
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROTATION_CW: cfg_in.rotation_cw       = csr_data[0];
            CSR_DELTA_GAIN:  cfg_in.delta_filter_gain = csr_data;
            CSR_MIN_FLOOR:   cfg_in.min_delta_floor   = csr_data[14:0];
            CSR_KAFC_SCALE:  cfg_in.kafc_scale        = csr_data;
            CSR_RPM_SHIFT:   cfg_in.rpm_filter_shift  = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rotation_cw: 1'b0, delta_filter_gain: 16'd206,
                     min_delta_floor: 15'd1310, kafc_scale: 16'd10294,
                     rpm_filter_shift: 4'd3};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bemf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_data (req_data),
      .deq_valid (q_valid),
      .deq_data  (q_data),
      .deq_pop   (q_pop)
   );

   bemf_back #(
      .POLE_PAIRS     (POLE_PAIRS),
      .WINDOW_SAMPLES (WINDOW_SAMPLES),
      .CORDIC_STAGES  (CORDIC_STAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .in_pop    (q_pop),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   // result beat register: back end hands off only into an empty slot
   assign res_ready = !out_vld_ff;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_vld_in = out_vld_ff;
      if (rsp_pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res_data;
      end
   end

   `BEMF_ASSERT_IMP(a_no_pop_when_empty_queue, q_pop, q_valid)
   `BEMF_ASSERT_NXT(a_handoff_fills_slot, res_valid && res_ready, !rsp_empty)
   `BEMF_ASSERT_NXT(a_pop_drains_slot, rsp_pop && !rsp_empty && !res_valid, rsp_empty)

endmodule
`default_nettype wire

>>> hdl/bemf_front.sv
// Input side: two-entry sample queue between the request port and the back end
`timescale 1ns / 1ps
`default_nettype none
module bemf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire bemf_pkg::req_type push_data,
   output logic                   deq_valid,
   output bemf_pkg::req_type      deq_data,
   input  wire logic              deq_pop
);
   import bemf_pkg::*;

   req_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign deq_valid = (cnt_ff != 2'd0);
   assign deq_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = deq_pop && deq_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> hdl/bemf_back.sv
// Back end: iterative CORDIC, speed filters, 60-degree divider and coefficient
`timescale 1ns / 1ps
`default_nettype none
module bemf_back #(
   parameter int POLE_PAIRS     = bemf_pkg::PolePairsDefault,
   parameter int WINDOW_SAMPLES = bemf_pkg::WindowSamplesDefault,
   parameter int CORDIC_STAGES  = bemf_pkg::CordicStagesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bemf_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   input  wire bemf_pkg::req_type in_data,
   output logic                   in_pop,
   output logic                   res_valid,
   output bemf_pkg::rsp_type      res_data,
   input  wire logic              res_ready
);
   import bemf_pkg::*;

   localparam int SixMult = POLE_PAIRS * 6;
   // reciprocal of the pole-pair count, exact for any 16-bit dividend
   localparam int RecipShift = 16 + $clog2(POLE_PAIRS);
   localparam int RecipMult  = ((1 << RecipShift) + POLE_PAIRS - 1) / POLE_PAIRS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CORD = 4'd1;
   localparam logic [3:0] S_ANG  = 4'd2;
   localparam logic [3:0] S_MUL1 = 4'd3;
   localparam logic [3:0] S_MUL2 = 4'd4;
   localparam logic [3:0] S_ERPM = 4'd5;
   localparam logic [3:0] S_SM1  = 4'd6;
   localparam logic [3:0] S_SM2  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_SIX  = 4'd9;
   localparam logic [3:0] S_COEF = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;
   localparam logic [3:0] S_RPM  = 4'd12;

   logic [3:0]         st_ff, st_in;
   // CORDIC
   logic signed [27:0] x_ff, x_in, y_ff, y_in;
   logic [23:0]        acc_ff, acc_in;
   logic [4:0]         it_ff, it_in;
   logic               zero_ff, zero_in;
   // angle and window
   logic [15:0]        raw_ff, raw_in, comp_ff, comp_in;
   logic [15:0]        prev_ff, prev_in, wsum_ff, wsum_in;
   logic [5:0]         wcnt_ff, wcnt_in;
   logic signed [15:0] wdelta_ff, wdelta_in, fd_ff, fd_in;
   logic signed [33:0] prod_ff, prod_in;
   logic [15:0]        erpm_ff, erpm_in, es1_ff, es1_in, es2_ff, es2_in;
   // divider
   logic [23:0]        rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic [15:0]        rpm_ff, rpm_in;
   logic [20:0]        held_ff, held_in;
   logic [14:0]        coeff_ff, coeff_in;

   // combinational helpers
   logic signed [27:0] xs, ys, x0, y0;
   logic [15:0]        raw_c, delta_c, sum_c, kk, kc;
   logic [6:0]         cnt_c;
   logic signed [32:0] mul2_c;
   logic signed [33:0] erpm_m;
   logic signed [16:0] sd;
   logic [24:0]        dsh;
   logic [24:0]        dtr;
   logic [14:0]        val_c;
   logic [30:0]        cprod;
   logic [37:0]        rprod;

   assign res_valid = (st_ff == S_DONE);
   assign in_pop    = (st_ff == S_IDLE) && in_valid;
   assign res_data  = '{comp_angle: comp_ff, raw_angle: raw_ff, mech_rpm: rpm_ff,
                        sixty_deg_time: held_ff, observer_coeff: coeff_ff};

   always_comb begin
      st_in = st_ff;   x_in = x_ff;   y_in = y_ff;   acc_in = acc_ff;
      it_in = it_ff;   zero_in = zero_ff;
      raw_in = raw_ff; comp_in = comp_ff; prev_in = prev_ff; wsum_in = wsum_ff;
      wcnt_in = wcnt_ff; wdelta_in = wdelta_ff; fd_in = fd_ff; prod_in = prod_ff;
      erpm_in = erpm_ff; es1_in = es1_ff; es2_in = es2_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; dcnt_in = dcnt_ff;
      rpm_in = rpm_ff; held_in = held_ff; coeff_in = coeff_ff;

      x0 = 28'(in_data.emf_beta) <<< 8;
      y0 = -(28'(in_data.emf_alpha) <<< 8);
      xs = x_ff >>> it_ff;
      ys = y_ff >>> it_ff;
      raw_c = zero_ff ? 16'd0 : acc_ff[23:8];
      delta_c = cfg.rotation_cw ? (prev_ff - raw_c) : (raw_c - prev_ff);
      sum_c = wsum_ff + delta_c;
      cnt_c = {1'b0, wcnt_ff} + 7'd1;
      kk = (cfg.delta_filter_gain > Q15_ONE_M1) ? Q15_ONE_M1 : cfg.delta_filter_gain;
      kc = Q15_ONE_M1 - kk;
      mul2_c = 33'(prod_ff) + 33'($signed({1'b0, kc}) * fd_ff);
      erpm_m = fd_ff * $signed(ERPM_FACTOR);
      sd = '0;
      dsh = {rem_ff, quo_ff[23]};
      dtr = dsh - {1'b0, dvs_ff};
      val_c = (fd_ff < $signed({1'b0, cfg.min_delta_floor})) ? cfg.min_delta_floor
                                                              : fd_ff[14:0];
      cprod = 31'(cfg.kafc_scale) * 31'(val_c);
      rprod = 38'(es2_ff) * 38'(RecipMult);

      unique case (st_ff)
         S_IDLE: begin
            if (in_valid) begin
               zero_in = (in_data.emf_alpha == 16'sd0) && (in_data.emf_beta == 16'sd0);
               it_in = 5'd0;
               if (x0 < 0) begin
                  x_in = -x0;  y_in = -y0;  acc_in = 24'h800000;
               end else begin
                  x_in = x0;   y_in = y0;   acc_in = 24'h000000;
               end
               st_in = S_CORD;
            end
         end
         S_CORD: begin
            if (y_ff >= 0) begin
               x_in = x_ff + ys;  y_in = y_ff - xs;
               acc_in = acc_ff + 24'(atan_lut(it_ff));
            end else begin
               x_in = x_ff - ys;  y_in = y_ff + xs;
               acc_in = acc_ff - 24'(atan_lut(it_ff));
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(CORDIC_STAGES - 1)) begin
               st_in = S_ANG;
            end
         end
         S_ANG: begin
            raw_in  = raw_c;
            comp_in = cfg.rotation_cw ? (raw_c - QUARTER_TURN) : (raw_c + QUARTER_TURN);
            prev_in = raw_c;
            if (cnt_c >= 7'(WINDOW_SAMPLES)) begin
               wdelta_in = $signed(sum_c);
               wsum_in = 16'd0;
               wcnt_in = 6'd0;
            end else begin
               wsum_in = sum_c;
               wcnt_in = cnt_c[5:0];
            end
            st_in = S_MUL1;
         end
         S_MUL1: begin
            prod_in = 34'($signed({1'b0, kk}) * wdelta_ff);
            st_in = S_MUL2;
         end
         S_MUL2: begin
            fd_in = $signed(mul2_c[30:15]);
            st_in = S_ERPM;
         end
         S_ERPM: begin
            erpm_in = (erpm_m < 0) ? 16'd0 : erpm_m[31:16];
            st_in = S_SM1;
         end
         S_SM1: begin
            sd = ($signed({1'b0, erpm_ff}) - $signed({1'b0, es1_ff})) >>> cfg.rpm_filter_shift;
            es1_in = es1_ff + sd[15:0];
            st_in = S_SM2;
         end
         S_SM2: begin
            sd = ($signed({1'b0, es1_ff}) - $signed({1'b0, es2_ff})) >>> cfg.rpm_filter_shift;
            es2_in = es2_ff + sd[15:0];
            st_in = S_RPM;
         end
         S_RPM: begin
            rpm_in = rprod[RecipShift +: 16];
            st_in = S_SIX;
         end
         S_DIV: begin
            if (dtr[24]) begin
               rem_in = dsh[23:0];
               quo_in = {quo_ff[22:0], 1'b0};
            end else begin
               rem_in = dtr[23:0];
               quo_in = {quo_ff[22:0], 1'b1};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd23) begin
               held_in = quo_in[20:0];
               st_in = S_COEF;
            end
         end
         S_SIX: begin
            if (rpm_ff != 16'd0) begin
               rem_in = 24'd0;
               quo_in = SIXTY_NUM;
               dvs_in = 24'(rpm_ff) * 24'(SixMult);
               dcnt_in = 5'd0;
               st_in = S_DIV;
            end else begin
               st_in = S_COEF;
            end
         end
         S_COEF: begin
            // the clamped delta is at most 15 bits, so the product never passes 32767 after the shift
            coeff_in = cprod[30:16];
            st_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         prev_ff <= '0;  wsum_ff <= '0;  wcnt_ff <= '0;  wdelta_ff <= '0;
         fd_ff <= '0;  es1_ff <= '0;  es2_ff <= '0;  held_ff <= '0;
      end else begin
         st_ff <= st_in;
         prev_ff <= prev_in;  wsum_ff <= wsum_in;  wcnt_ff <= wcnt_in;
         wdelta_ff <= wdelta_in;  fd_ff <= fd_in;  es1_ff <= es1_in;
         es2_ff <= es2_in;  held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  y_ff <= y_in;  acc_ff <= acc_in;  it_ff <= it_in;
      zero_ff <= zero_in;  raw_ff <= raw_in;  comp_ff <= comp_in;
      prod_ff <= prod_in;  erpm_ff <= erpm_in;
      rem_ff <= rem_in;  quo_ff <= quo_in;  dvs_ff <= dvs_in;  dcnt_ff <= dcnt_in;
      rpm_ff <= rpm_in;  coeff_ff <= coeff_in;
   end

endmodule
`default_nettype wire

>>> sim/backemf_angle_speed_estimator_tb.sv
// Self-checking testbench of the back-EMF angle and speed estimator
`timescale 1ns / 1ps
`default_nettype none
module backemf_angle_speed_estimator_tb;
   import bemf_pkg::*;

   localparam int NPOLE      = 4;
   localparam int NWIN       = 20;
   localparam int NSTAGE     = 16;
   localparam int DRAIN_WAIT = 200;     // settle time after the queues drain
   localparam int DOG_LIMIT  = 20000;   // cycles without any accepted beat

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   req_type           req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   backemf_angle_speed_estimator i_dut (
      .clock, .reset, .req_push, .req_full, .req_data, .rsp_empty, .rsp_pop,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- shadow of the block: configuration and estimator state ----
   cfg_type     shadow_cfg;
   logic [15:0] last_angle;
   logic [15:0] win_sum;
   int          win_count;
   int          win_delta;
   int          filt_delta;
   logic [15:0] smooth_one;
   logic [15:0] smooth_two;
   logic [20:0] held_time;

   req_type sample_queue[$];     // samples waiting for the driver
   req_type inflight_samples[$]; // accepted samples whose results are due
   int      fail_count = 0;
   bit      gaps_on = 1'b1;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int sext16(input logic [15:0] v);
      return int'($signed(v));
   endfunction

   // vectoring CORDIC, accumulator in 2^-24 turn
   function automatic logic [15:0] cordic_turns(input int y_in, input int x_in);
      int x, y, xs, ys, acc;
      logic [31:0] acc_u;
      x = x_in * 256;
      y = y_in * 256;
      acc = 0;
      if (x_in == 0 && y_in == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 8388608;
      end
      for (int i = 0; i < NSTAGE; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys;
            y -= xs;
            acc += int'(atan_lut(5'(i)));
         end else begin
            x -= ys;
            y += xs;
            acc -= int'(atan_lut(5'(i)));
         end
      end
      acc_u = acc;
      return acc_u[23:8];
   endfunction

   function automatic logic [15:0] shift_smooth(input logic [15:0] y, input logic [15:0] x,
                                                input logic [3:0] s);
      longint d;
      d = (longint'(x) - longint'(y)) >>> s;
      return 16'(longint'(y) + d);
   endfunction

   // advance the shadow state by one sample whose angle is ang
   function automatic rsp_type estimate_step(input logic [15:0] ang);
      rsp_type     r;
      logic [15:0] delta, rpm;
      longint      acc, erpm;
      int          k, val;
      logic [31:0] coeff;
      if (shadow_cfg.rotation_cw) begin
         r.comp_angle = ang - QUARTER_TURN;
         delta = last_angle - ang;
      end else begin
         r.comp_angle = ang + QUARTER_TURN;
         delta = ang - last_angle;
      end
      r.raw_angle = ang;
      win_sum = win_sum + delta;
      last_angle = ang;
      win_count++;
      if (win_count >= NWIN) begin
         win_delta = sext16(win_sum);
         win_count = 0;
         win_sum = '0;
      end
      k = int'(shadow_cfg.delta_filter_gain);
      if (k > 32768) k = 32768;   // excess gain saturates at unity
      acc = longint'(k) * win_delta + longint'(32768 - k) * filt_delta;
      acc = acc >>> 15;
      filt_delta = sext16(acc[15:0]);
      erpm = (longint'(filt_delta) * 60000) >>> 16;
      if (erpm < 0) erpm = 0;
      smooth_one = shift_smooth(smooth_one, erpm[15:0], shadow_cfg.rpm_filter_shift);
      smooth_two = shift_smooth(smooth_two, smooth_one, shadow_cfg.rpm_filter_shift);
      rpm = smooth_two / NPOLE;
      if (rpm > 0) held_time = 21'(32'd10000000 / (32'(rpm) * NPOLE * 6));
      r.mech_rpm = rpm;
      r.sixty_deg_time = held_time;
      val = filt_delta;
      if (val < int'(shadow_cfg.min_delta_floor)) val = int'(shadow_cfg.min_delta_floor);
      coeff = (32'(shadow_cfg.kafc_scale) * 32'(val)) >> 16;
      if (coeff > 32767) coeff = 32767;
      r.observer_coeff = coeff[14:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 5);
      return $urandom_range(20, 100);
   endfunction

   // ---- driver: feeds sample beats from the queue ----
   int push_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) inflight_samples.push_back(req_data);
         if (req_push && req_full) begin
            // hold the beat until taken
         end else if (push_gap > 0) begin
            push_gap <= push_gap - 1;
            req_push <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_data <= sample_queue.pop_front();
            req_push <= 1'b1;
            push_gap <= pick_gap();
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---- monitor: checks each result beat against the shadow ----
   int pop_gap = 0;
   always @(posedge clock) begin
      req_type     smp;
      rsp_type     want;
      logic [15:0] exact_ang, diff, use_ang;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (inflight_samples.size() == 0) begin
               report_mismatch("result beat with no sample outstanding");
            end else begin
               smp = inflight_samples.pop_front();
               exact_ang = cordic_turns(-sext16(smp.emf_alpha), sext16(smp.emf_beta));
               diff = rsp_data.raw_angle - exact_ang;
               // angle may be off by one LSB; the block then carries its own angle on
               use_ang = (diff == 16'd0 || diff == 16'd1 || diff == 16'hFFFF)
                         ? rsp_data.raw_angle : exact_ang;
               want = estimate_step(use_ang);
               if (use_ang != rsp_data.raw_angle)
                  report_mismatch($sformatf("raw_angle %0d want %0d (a=%0d b=%0d)",
                     rsp_data.raw_angle, exact_ang, smp.emf_alpha, smp.emf_beta));
               if (rsp_data.comp_angle != want.comp_angle)
                  report_mismatch($sformatf("comp_angle %0d want %0d",
                     rsp_data.comp_angle, want.comp_angle));
               if (rsp_data.mech_rpm != want.mech_rpm)
                  report_mismatch($sformatf("mech_rpm %0d want %0d",
                     rsp_data.mech_rpm, want.mech_rpm));
               if (rsp_data.sixty_deg_time != want.sixty_deg_time)
                  report_mismatch($sformatf("sixty_deg_time %0d want %0d",
                     rsp_data.sixty_deg_time, want.sixty_deg_time));
               if (rsp_data.observer_coeff != want.observer_coeff)
                  report_mismatch($sformatf("observer_coeff %0d want %0d",
                     rsp_data.observer_coeff, want.observer_coeff));
            end
         end
         if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap <= pick_gap();
         end
      end
   end

   // ---- watchdog: any accepted beat restarts the count ----
   int dog_count = 0;
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         dog_count <= 0;
      end else if (dog_count >= DOG_LIMIT) begin
         $display("backemf_angle_speed_estimator_tb NOT OK");
         $finish;
      end else begin
         dog_count <= dog_count + 1;
      end
   end

   // one CSR beat; shadow follows the masking rules of each register
   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ROTATION_CW: shadow_cfg.rotation_cw       = val[0];
         CSR_DELTA_GAIN:  shadow_cfg.delta_filter_gain = val;
         CSR_MIN_FLOOR:   shadow_cfg.min_delta_floor   = val[14:0];
         CSR_KAFC_SCALE:  shadow_cfg.kafc_scale        = val;
         CSR_RPM_SHIFT:   shadow_cfg.rpm_filter_shift  = val[3:0];
         default: ;   // unknown index: ignored
      endcase
   endtask

   task automatic wait_idle();
      while (sample_queue.size() > 0 || inflight_samples.size() > 0 || req_push)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic push_sample(input int a, input int b);
      req_type s;
      s.emf_alpha = 16'(a);
      s.emf_beta  = 16'(b);
      sample_queue.push_back(s);
   endtask

   // rotating phasor, mostly well-formed with a few noise beats mixed in
   task automatic queue_rotation(input int count);
      real theta, step, amp;
      theta = $urandom_range(0, 65535) / 65536.0 * 6.283185307;
      step  = ($urandom_range(0, 4000) - 2000.0) / 65536.0 * 6.283185307;
      amp   = $urandom_range(50, 32767);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
         end else begin
            push_sample(int'(-amp * $sin(theta)), int'(amp * $cos(theta)));
         end
         theta += step;
         if ($urandom_range(0, 49) == 0) step = -step;   // direction reversal
      end
   endtask

   initial begin
      shadow_cfg = '{rotation_cw: 1'b0, delta_filter_gain: 16'd206, min_delta_floor: 15'd1310,
                     kafc_scale: 16'd10294, rpm_filter_shift: 4'd3};
      last_angle = '0; win_sum = '0; win_count = 0; win_delta = 0; filt_delta = 0;
      smooth_one = '0; smooth_two = '0; held_time = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero vector, axis and corner extremes, and unit-size vectors
      push_sample(0, 0);
      push_sample(32767, 0);
      push_sample(-32768, 0);
      push_sample(0, 32767);
      push_sample(0, -32768);
      push_sample(32767, 32767);
      push_sample(-32768, -32768);
      push_sample(32767, -32768);
      push_sample(-32768, 32767);
      push_sample(1, -1);
      push_sample(-1, 1);
      push_sample(0, 1);
      push_sample(1, 0);
      push_sample(0, 0);
      wait_idle();

      // fast filter, no smoothing, clockwise, excess gain, masked floor, full scale, unused indices
      csr_write(CSR_ROTATION_CW, 16'hFFFF);
      csr_write(CSR_DELTA_GAIN, 16'hFFFF);
      csr_write(CSR_MIN_FLOOR, 16'hFFFF);
      csr_write(CSR_KAFC_SCALE, 16'hFFFF);
      csr_write(CSR_RPM_SHIFT, 16'd0);
      csr_write(3'd5, 16'h1234);
      csr_write(3'd7, 16'hFFFF);
      for (int i = 0; i < 8; i++) push_sample(0, 0);
      queue_rotation(110);
      wait_idle();

      // unity gain, counter-clockwise, no floor, no gaps
      csr_write(CSR_ROTATION_CW, 16'd0);
      csr_write(CSR_DELTA_GAIN, 16'd32768);
      csr_write(CSR_MIN_FLOOR, 16'd0);
      csr_write(CSR_KAFC_SCALE, 16'd40000);
      csr_write(CSR_RPM_SHIFT, 16'd1);
      gaps_on = 1'b0;
      queue_rotation(120);
      wait_idle();
      gaps_on = 1'b1;

      // zero gain, widest smoothing, zero scale
      csr_write(CSR_DELTA_GAIN, 16'd0);
      csr_write(CSR_RPM_SHIFT, 16'd15);
      csr_write(CSR_KAFC_SCALE, 16'd0);
      queue_rotation(100);
      wait_idle();

      // random settings, several phases
      for (int p = 0; p < 4; p++) begin
         csr_write(CSR_ROTATION_CW, 16'($urandom_range(0, 1)));
         csr_write(CSR_DELTA_GAIN, 16'($urandom_range(0, 32768)));
         csr_write(CSR_MIN_FLOOR, 16'($urandom_range(0, 32767)));
         csr_write(CSR_KAFC_SCALE, 16'($urandom_range(0, 65535)));
         csr_write(CSR_RPM_SHIFT, 16'($urandom_range(0, 6)));
         queue_rotation(90);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("backemf_angle_speed_estimator_tb OK");
      end else begin
         $display("backemf_angle_speed_estimator_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/bemf_pkg.sv
hdl/bemf_front.sv
hdl/bemf_back.sv
hdl/backemf_angle_speed_estimator.sv
sim/backemf_angle_speed_estimator_tb.sv
